### rtl/core/sfd_pkg.sv
// Shared widths, register indexes and reset values of the serial frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int ByteWidth   = 8;
    localparam int WordWidth   = 32;
    localparam int WordCount   = 4;
    localparam int BytesInWord = WordWidth / ByteWidth;
    localparam int CountWidth  = 5;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = ByteWidth;

    localparam logic [CountWidth-1:0] LongPayload  = CountWidth'(16);
    localparam logic [CountWidth-1:0] ShortPayload = CountWidth'(8);

    localparam logic [CfgIdxWidth-1:0] CfgFrameKind  = CfgIdxWidth'(0);
    localparam logic [CfgIdxWidth-1:0] CfgHeadFirst  = CfgIdxWidth'(1);
    localparam logic [CfgIdxWidth-1:0] CfgHeadSecond = CfgIdxWidth'(2);
    localparam logic [CfgIdxWidth-1:0] CfgTailFirst  = CfgIdxWidth'(3);
    localparam logic [CfgIdxWidth-1:0] CfgTailSecond = CfgIdxWidth'(4);

    localparam logic [ByteWidth-1:0] HeadFirstReset  = 8'd73;
    localparam logic [ByteWidth-1:0] HeadSecondReset = 8'd82;
    localparam logic [ByteWidth-1:0] TailFirstReset  = 8'd79;
    localparam logic [ByteWidth-1:0] TailSecondReset = 8'd78;

    localparam logic StatusOk      = 1'b0;
    localparam logic StatusBadTail = 1'b1;
    localparam logic KindLong      = 1'b0;

endpackage

### rtl/core/sfd_in_if.sv
// Valid/ready channel that carries one received byte per item.
`timescale 1ns / 1ps

interface sfd_in_if;
    import sfd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/sfd_out_if.sv
// Valid/ready channel that carries one decoded frame per item.
`timescale 1ns / 1ps

interface sfd_out_if;
    import sfd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 frame_status;
    logic                 enemy_colour;
    logic [1:0]           aim_target;
    logic [2:0]           tactic_number;
    logic [WordWidth-1:0] word_a;
    logic [WordWidth-1:0] word_b;
    logic [WordWidth-1:0] word_c;
    logic [WordWidth-1:0] word_d;

    modport source (
        output valid, output frame_status, output enemy_colour, output aim_target,
        output tactic_number, output word_a, output word_b, output word_c,
        output word_d, input ready
    );
    modport sink (
        input valid, input frame_status, input enemy_colour, input aim_target,
        input tactic_number, input word_a, input word_b, input word_c,
        input word_d, output ready
    );
endinterface

### rtl/core/serial_frame_deframer_top.sv
// Serial frame deframer: header hunt, payload collection, tail check and frame output.
//
//   Channel   Direction  Item
//   rx_item   in         one received link byte
//   res_item  out        one decoded frame with tail status
//   cfg_*     in         register write, no handshake
//
// Each byte passes an input register, then the frame state machine, and a frame
// lands in the result register after its second tail byte; throughput is one byte
// per cycle except while a byte stalls in the input register as below.
// A byte stalls in the input register only when it closes a frame while the
// result register still holds an untaken frame.
// Reset clears the state machine and loads the default header and tail bytes.
`timescale 1ns / 1ps

module serial_frame_deframer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    sfd_in_if.sink                           rx_item,
    sfd_out_if.source                        res_item,
    input  logic                             cfg_we,
    input  logic [sfd_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [sfd_pkg::CfgDataWidth-1:0] cfg_data
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1     = 3'd0,
        PH_HUNT2     = 3'd1,
        PH_MODE      = 3'd2,
        PH_PAYLOAD   = 3'd3,
        PH_TAIL1     = 3'd4,
        PH_TAIL2_OK  = 3'd5,
        PH_TAIL2_BAD = 3'd6
    } phase_t;

    logic                 frame_kind_reg;
    logic [ByteWidth-1:0] head_first_reg;
    logic [ByteWidth-1:0] head_second_reg;
    logic [ByteWidth-1:0] tail_first_reg;
    logic [ByteWidth-1:0] tail_second_reg;

    logic                 in_valid_reg;
    logic [ByteWidth-1:0] in_byte_reg;

    phase_t                phase_reg, phase_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [ByteWidth-1:0]  mode_reg, mode_next;
    logic [WordCount-1:0][BytesInWord-1:0][ByteWidth-1:0] word_reg;

    logic                 out_valid_reg;
    logic                 status_reg;
    logic                 colour_reg;
    logic [1:0]           target_reg;
    logic [2:0]           tactic_reg;
    logic [WordWidth-1:0] word_a_reg, word_b_reg, word_c_reg, word_d_reg;

    logic                  is_tail2;
    logic                  stall;
    logic                  advance;
    logic                  emit;
    logic                  bad_tail;
    logic                  word_we;
    logic                  is_long;
    logic [CountWidth-1:0] count_inc;
    logic [CountWidth-1:0] payload_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_kind_reg  <= KindLong;
            head_first_reg  <= HeadFirstReset;
            head_second_reg <= HeadSecondReset;
            tail_first_reg  <= TailFirstReset;
            tail_second_reg <= TailSecondReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgFrameKind:  frame_kind_reg  <= cfg_data[0];
                CfgHeadFirst:  head_first_reg  <= cfg_data;
                CfgHeadSecond: head_second_reg <= cfg_data;
                CfgTailFirst:  tail_first_reg  <= cfg_data;
                CfgTailSecond: tail_second_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign is_tail2 = (phase_reg == PH_TAIL2_OK) || (phase_reg == PH_TAIL2_BAD);
    assign stall    = in_valid_reg && is_tail2 && out_valid_reg && !res_item.ready;
    assign advance  = in_valid_reg && !stall;
    assign rx_item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_item.ready)
        begin
            in_valid_reg <= rx_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_item.valid && rx_item.ready)
        begin
            in_byte_reg <= rx_item.rx_byte;
        end
    end

    assign is_long     = (frame_kind_reg == KindLong);
    assign payload_len = is_long ? LongPayload : ShortPayload;
    assign count_inc   = count_reg + CountWidth'(1);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        emit       = 1'b0;
        bad_tail   = 1'b0;
        word_we    = 1'b0;
        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (in_byte_reg == head_second_reg)
                begin
                    count_next = '0;
                    phase_next = is_long ? PH_MODE : PH_PAYLOAD;
                end
                else if (in_byte_reg != head_first_reg)
                begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_MODE:
            begin
                mode_next  = in_byte_reg;
                count_next = '0;
                phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                word_we    = 1'b1;
                count_next = count_inc;
                if (count_inc >= payload_len)
                begin
                    phase_next = PH_TAIL1;
                end
            end
            PH_TAIL1:
            begin
                phase_next = (in_byte_reg == tail_first_reg) ? PH_TAIL2_OK : PH_TAIL2_BAD;
            end
            PH_TAIL2_OK, PH_TAIL2_BAD:
            begin
                emit       = 1'b1;
                bad_tail   = (phase_reg == PH_TAIL2_BAD) || (in_byte_reg != tail_second_reg);
                phase_next = PH_HUNT1;
                count_next = '0;
            end
            default:
            begin
                phase_next = (in_byte_reg == head_first_reg) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT1;
            count_reg     <= '0;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                mode_reg  <= mode_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_item.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && word_we)
        begin
            word_reg[count_reg[3:2]][count_reg[1:0]] <= in_byte_reg;
        end
    end

    // The frame fields follow the frame kind in force when the last tail byte is seen.
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            status_reg <= bad_tail ? StatusBadTail : StatusOk;
            colour_reg <= is_long ? mode_reg[0] : 1'b0;
            target_reg <= is_long ? mode_reg[2:1] : 2'b00;
            tactic_reg <= is_long ? mode_reg[5:3] : 3'b000;
            word_a_reg <= word_reg[0];
            word_b_reg <= word_reg[1];
            word_c_reg <= is_long ? word_reg[2] : '0;
            word_d_reg <= is_long ? word_reg[3] : '0;
        end
    end

    assign res_item.valid         = out_valid_reg;
    assign res_item.frame_status  = status_reg;
    assign res_item.enemy_colour  = colour_reg;
    assign res_item.aim_target    = target_reg;
    assign res_item.tactic_number = tactic_reg;
    assign res_item.word_a        = word_a_reg;
    assign res_item.word_b        = word_b_reg;
    assign res_item.word_c        = word_c_reg;
    assign res_item.word_d        = word_d_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LongPayload)
        else $error("Payload byte count ran past the long payload length.");

    a_emit_returns_to_hunt : assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_tail2 |=> phase_reg == PH_HUNT1 && out_valid_reg)
        else $error("A closed frame did not reach the result register or resume hunting.");

    a_stall_holds_byte : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                     && $stable(phase_reg))
        else $error("A stalled byte was lost or the state moved while stalled.");

    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(is_tail2 && advance))
        else $error("A frame appeared without a second tail byte.");

endmodule

### verif/tb_serial_frame_deframer_top.sv
// Self-checking testbench for the serial frame deframer with an in-bench frame predictor.
`timescale 1ns / 1ps

module tb_serial_frame_deframer_top;
    import sfd_pkg::*;

    localparam int RandomBytes  = 1350;
    localparam int SettleCycles = 6;

    typedef enum logic [2:0] {
        HuntFirst,
        HuntSecond,
        TakeMode,
        TakePayload,
        TailFirst,
        TailSecondOk,
        TailSecondBad
    } hunt_phase_t;

    typedef struct packed {
        logic                 frame_status;
        logic                 enemy_colour;
        logic [1:0]           aim_target;
        logic [2:0]           tactic_number;
        logic [WordWidth-1:0] word_a;
        logic [WordWidth-1:0] word_b;
        logic [WordWidth-1:0] word_c;
        logic [WordWidth-1:0] word_d;
    } frame_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    sfd_in_if  rx_if ();
    sfd_out_if res_if ();

    serial_frame_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_item   (rx_if),
        .res_item  (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    logic                 kind_q        = KindLong;
    logic [ByteWidth-1:0] head_first_q  = HeadFirstReset;
    logic [ByteWidth-1:0] head_second_q = HeadSecondReset;
    logic [ByteWidth-1:0] tail_first_q  = TailFirstReset;
    logic [ByteWidth-1:0] tail_second_q = TailSecondReset;

    hunt_phase_t           phase_q     = HuntFirst;
    logic [CountWidth-1:0] payload_cnt = '0;
    logic [ByteWidth-1:0]  mode_q      = '0;
    logic [WordWidth-1:0]  words_q [WordCount];

    frame_t frames_due [$];
    int     mismatches  = 0;
    int     bytes_sent  = 0;
    bit     rx_idle_on  = 1'b1;
    bit     res_idle_on = 1'b1;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // Advances the frame state by one accepted byte and queues the frame it closes.
    function automatic void decode_byte(logic [ByteWidth-1:0] rx);
        frame_t                f;
        logic                  is_long;
        logic [CountWidth-1:0] limit;
        is_long = (kind_q == KindLong);
        limit   = is_long ? LongPayload : ShortPayload;
        case (phase_q)
            HuntSecond:
            begin
                if (rx == head_second_q)
                begin
                    payload_cnt = '0;
                    phase_q     = is_long ? TakeMode : TakePayload;
                end
                else if (rx != head_first_q)
                begin
                    phase_q = HuntFirst;
                end
            end
            TakeMode:
            begin
                mode_q      = rx;
                payload_cnt = '0;
                phase_q     = TakePayload;
            end
            TakePayload:
            begin
                words_q[payload_cnt[3:2]][{payload_cnt[1:0], 3'b000} +: 8] = rx;
                payload_cnt = payload_cnt + CountWidth'(1);
                if (payload_cnt >= limit)
                begin
                    phase_q = TailFirst;
                end
            end
            TailFirst:
            begin
                phase_q = (rx == tail_first_q) ? TailSecondOk : TailSecondBad;
            end
            TailSecondOk, TailSecondBad:
            begin
                f.frame_status  = (phase_q == TailSecondBad || rx != tail_second_q)
                                  ? StatusBadTail : StatusOk;
                f.enemy_colour  = is_long ? mode_q[0] : 1'b0;
                f.aim_target    = is_long ? mode_q[2:1] : 2'b00;
                f.tactic_number = is_long ? mode_q[5:3] : 3'b000;
                f.word_a        = words_q[0];
                f.word_b        = words_q[1];
                f.word_c        = is_long ? words_q[2] : '0;
                f.word_d        = is_long ? words_q[3] : '0;
                frames_due.push_back(f);
                phase_q     = HuntFirst;
                payload_cnt = '0;
            end
            default:
            begin
                phase_q = (rx == head_first_q) ? HuntSecond : HuntFirst;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [ByteWidth-1:0] value);
        int gap;
        gap = rx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            rx_if.valid   = 1'b0;
            rx_if.rx_byte = 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = value;
        do @(posedge clk); while (rx_if.ready !== 1'b1);
        decode_byte(value);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [WordWidth-1:0] value);
        for (int i = 0; i < BytesInWord; i++)
        begin
            send_byte(value[8*i +: 8]);
        end
    endtask

    task automatic wait_frames_done();
        @(negedge clk);
        rx_if.valid = 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
    endtask

    task automatic drain();
        wait_frames_done();
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [ByteWidth-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CfgFrameKind:  kind_q        = val[0];
            CfgHeadFirst:  head_first_q  = val;
            CfgHeadSecond: head_second_q = val;
            CfgTailFirst:  tail_first_q  = val;
            CfgTailSecond: tail_second_q = val;
            default: ;
        endcase
    endtask

    function automatic logic [ByteWidth-1:0] pick_reg_value(logic [ByteWidth-1:0] dflt);
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: return dflt;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [ByteWidth-1:0] payload_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_frame(input bit spoil_first, input bit spoil_second);
        int len;
        len = (kind_q == KindLong) ? 16 : 8;
        send_byte(head_first_q);
        send_byte(head_second_q);
        if (kind_q == KindLong)
        begin
            send_byte(8'($urandom));
        end
        repeat (len) send_byte(payload_byte());
        send_byte(spoil_first ? tail_first_q ^ 8'($urandom_range(1, 255)) : tail_first_q);
        send_byte(spoil_second ? tail_second_q ^ 8'($urandom_range(1, 255)) : tail_second_q);
    endtask

    // Reset settings, a noise byte and a repeated first header byte before a long frame.
    task automatic test_long_frame();
        send_byte(8'h00);
        send_byte(HeadFirstReset);
        send_byte(HeadFirstReset);
        send_byte(HeadSecondReset);
        send_byte(8'hFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h8000_0001);
        send_word(32'h7FFF_FFFE);
        send_byte(TailFirstReset);
        send_byte(TailSecondReset);
        drain();
    endtask

    // A short frame without idling whose second tail byte is wrong.
    task automatic test_short_bad_tail();
        rx_idle_on  = 1'b0;
        res_idle_on = 1'b0;
        write_reg(CfgFrameKind, 8'd1);
        send_byte(head_first_q);
        send_byte(head_second_q);
        send_word(32'h0000_00FF);
        send_word(32'hFF00_0000);
        send_byte(tail_first_q);
        send_byte(~tail_second_q);
        drain();
        rx_idle_on  = 1'b1;
        res_idle_on = 1'b1;
    endtask

    // The frame kind flips from long to short after ten payload bytes.
    task automatic test_kind_switch();
        write_reg(CfgFrameKind, 8'd0);
        send_byte(head_first_q);
        send_byte(head_second_q);
        send_byte(8'h2A);
        send_word(32'h1234_5678);
        send_word(32'h9ABC_DEF0);
        send_byte(8'h55);
        send_byte(8'hAA);
        drain();
        write_reg(CfgFrameKind, 8'd1);
        send_byte(8'h3C);
        send_byte(tail_first_q);
        send_byte(tail_second_q);
        drain();
    endtask

    // Phases of random settings with mostly well-formed frames, noise and cut-off frames.
    task automatic test_random_traffic();
        int  frames;
        int  pick;
        bit  first_pause;
        first_pause = 1'b1;
        while (bytes_sent < RandomBytes)
        begin
            write_reg(CfgFrameKind, 8'($urandom_range(0, 1)));
            write_reg(CfgHeadFirst, pick_reg_value(HeadFirstReset));
            write_reg(CfgHeadSecond, ($urandom_range(0, 5) == 0) ? head_first_q
                                     : pick_reg_value(HeadSecondReset));
            write_reg(CfgTailFirst, pick_reg_value(TailFirstReset));
            write_reg(CfgTailSecond, pick_reg_value(TailSecondReset));
            rx_idle_on  = ($urandom_range(0, 3) != 0);
            res_idle_on = ($urandom_range(0, 3) != 0);
            frames = $urandom_range(3, 10);
            repeat (frames)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    send_frame($urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0);
                end
                else if (pick == 7)
                begin
                    repeat ($urandom_range(1, 4))
                        send_byte(($urandom_range(0, 1) == 0) ? head_first_q : 8'($urandom));
                end
                else if (pick == 8)
                begin
                    send_byte(head_first_q);
                    send_byte(head_second_q);
                    repeat ($urandom_range(0, 6)) send_byte(payload_byte());
                end
                if (pick == 9 || first_pause)
                begin
                    wait_frames_done();
                    first_pause = 1'b0;
                end
            end
            drain();
        end
    endtask

    initial
    begin
        int stall;
        res_if.ready = 1'b0;
        forever
        begin
            stall = res_idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                res_if.ready = 1'b0;
                repeat (stall) @(posedge clk);
            end
            @(negedge clk);
            res_if.ready = 1'b1;
            do @(posedge clk); while (res_if.valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (frames_due.size() == 0)
            begin
                report_mismatch("frame arrived with none expected");
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("frame_status", 32'(res_if.frame_status), 32'(want.frame_status));
                check_field("enemy_colour", 32'(res_if.enemy_colour), 32'(want.enemy_colour));
                check_field("aim_target", 32'(res_if.aim_target), 32'(want.aim_target));
                check_field("tactic_number", 32'(res_if.tactic_number),
                            32'(want.tactic_number));
                check_field("word_a", res_if.word_a, want.word_a);
                check_field("word_b", res_if.word_b, want.word_b);
                check_field("word_c", res_if.word_c, want.word_c);
                check_field("word_d", res_if.word_d, want.word_d);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < WordCount; i++)
        begin
            words_q[i] = '0;
        end
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_long_frame();
        test_short_bad_tail();
        test_kind_switch();
        test_random_traffic();
        if (mismatches == 0 && frames_due.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
